/* rtl/core/kernel_averaged_bilinear_sampler_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the kernel averaged bilinear sampler
// Concurrent checks clocked on clock, quiet while reset is high.
// ----------------------------------------------------------------------------
`ifndef KERNEL_AVERAGED_BILINEAR_SAMPLER_CORE_MACROS_SVH
`define KERNEL_AVERAGED_BILINEAR_SAMPLER_CORE_MACROS_SVH

`ifndef SYNTH
// Condition a implies condition c in the same cycle
`define KABS_ASSERT_IMP(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("kabs assertion failed");
// Condition a implies condition c in the next cycle
`define KABS_ASSERT_NXT(label, a, c) \
   label: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("kabs assertion failed");
`else
`define KABS_ASSERT_IMP(label, a, c)
`define KABS_ASSERT_NXT(label, a, c)
`endif

`endif

/* rtl/core/kabs_pkg.sv */
// ----------------------------------------------------------------------------
// kabs_pkg
// Shared constants and types of the kernel averaged bilinear sampler.
// ----------------------------------------------------------------------------
package kabs_pkg;

   // Image and kernel geometry
   localparam int IMAGE_SIDE = 256;
   localparam int KERNEL_MAX = 16;
   localparam int IX_W       = $clog2(IMAGE_SIDE);
   localparam int KCNT_W     = (KERNEL_MAX > 1) ? $clog2(KERNEL_MAX) : 1;
   localparam int K_W        = KCNT_W + 1;
   localparam int KK_W       = $clog2(KERNEL_MAX * KERNEL_MAX + 1);
   localparam int COEF_W     = KCNT_W + 2;

   // Banked image store: four banks by row and column parity
   localparam int BANKS      = 4;
   localparam int BANK_AW    = 2 * (IX_W - 1);
   localparam int BANK_DEPTH = 2 ** BANK_AW;

   // Arithmetic widths
   localparam int PIX_W      = 16;
   localparam int FR_W       = 17;
   localparam int POS_W      = 39;
   localparam int OFF_W      = 63;
   localparam int R_W        = 33;
   localparam int SAMPLE_W   = 48;
   localparam int SUM_W      = SAMPLE_W + $clog2(KERNEL_MAX * KERNEL_MAX);
   localparam int DCNT_W     = $clog2(SUM_W + 1);

   localparam logic [FR_W-1:0]  FR_ONE     = FR_W'(65536);
   localparam logic [OFF_W-1:0] CENTRE_Q16 = OFF_W'((IMAGE_SIDE - 1) / 2) << 16;
   localparam logic [OFF_W-1:0] TOP_Q16    = OFF_W'(IMAGE_SIDE - 1) << 16;
   localparam logic [OFF_W-1:0] EDGE_Q16   = TOP_Q16 - CENTRE_Q16;

   // Configuration port
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 32;

   typedef enum logic [CSR_AW-1:0] {
      CSR_X_SCALE      = 3'd0,
      CSR_Y_SCALE      = 3'd1,
      CSR_X_HALF_WIDTH = 3'd2,
      CSR_Y_HALF_WIDTH = 3'd3,
      CSR_KERNEL_SIDE  = 3'd4,
      CSR_KERNEL_PITCH = 3'd5,
      CSR_OUTSIDE      = 3'd6
   } csr_index_type;

   // Settings seen by the sample pipeline
   typedef struct packed {
      logic [31:0]      x_scale;
      logic [31:0]      y_scale;
      logic [30:0]      x_half_width;
      logic [30:0]      y_half_width;
      logic [30:0]      kernel_pitch;
      logic [PIX_W-1:0] outside_value;
   } cfg_type;

   // One sample point issued to the pipeline
   typedef struct packed {
      logic                     valid;
      logic signed [31:0]       query_x;
      logic signed [31:0]       query_y;
      logic signed [COEF_W-1:0] coef_x;
      logic signed [COEF_W-1:0] coef_y;
   } smp_in_type;

   // Image store write port, one enable per bank
   typedef struct packed {
      logic [BANKS-1:0]   we;
      logic [BANK_AW-1:0] addr;
      logic [PIX_W-1:0]   data;
   } wr_type;

endpackage

/* rtl/core/kabs_ram.sv */
// ----------------------------------------------------------------------------
// kabs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module kabs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16384,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/kabs_sample_pipe.sv */
// ----------------------------------------------------------------------------
// kabs_sample_pipe
// Six stage pipeline: one sample point in per cycle, one Q0.48 sample out.
// Holds the four parity banks of the image store.
// ----------------------------------------------------------------------------
module kabs_sample_pipe (
   input  logic                            clock,
   input  logic                            reset,
   input  kabs_pkg::cfg_type               cfg,
   input  kabs_pkg::smp_in_type            smp_in,
   input  kabs_pkg::wr_type                wr,
   output logic                            out_valid,
   output logic [kabs_pkg::SAMPLE_W-1:0]   out_sample,
   output logic                            busy
);

   typedef struct packed {
      logic [kabs_pkg::IX_W-1:0] ix;
      logic [kabs_pkg::FR_W-1:0] fr;
   } pix_type;

   // Map an offset from the centre to a pixel index and fraction
   function automatic pix_type to_pixel(input logic neg, input logic [kabs_pkg::OFF_W-1:0] off);
      pix_type                     p;
      logic [kabs_pkg::OFF_W-1:0]  idx;
      idx  = neg ? (kabs_pkg::CENTRE_Q16 - off) : (kabs_pkg::CENTRE_Q16 + off);
      p.ix = idx[16 +: kabs_pkg::IX_W];
      p.fr = kabs_pkg::FR_W'(idx[15:0]);
      if (neg && (off > kabs_pkg::CENTRE_Q16)) begin
         p.ix = '0;
         p.fr = '0;
      end else if (!neg && (off >= kabs_pkg::EDGE_Q16)) begin
         p.ix = kabs_pkg::IX_W'(kabs_pkg::IMAGE_SIDE - 2);
         p.fr = kabs_pkg::FR_ONE;
      end
      return p;
   endfunction

   // Stage 1: sample position in half units
   logic                              s1_valid_ff;
   logic signed [kabs_pkg::POS_W-1:0] s1_px_ff, s1_py_ff;
   logic signed [kabs_pkg::POS_W-1:0] s1_px_in, s1_py_in;
   logic signed [37:0]                prod_x, prod_y;

   assign prod_x   = smp_in.coef_x * $signed({1'b0, cfg.kernel_pitch});
   assign prod_y   = smp_in.coef_y * $signed({1'b0, cfg.kernel_pitch});
   assign s1_px_in = (kabs_pkg::POS_W'(smp_in.query_x) <<< 1) + kabs_pkg::POS_W'(prod_x);
   assign s1_py_in = (kabs_pkg::POS_W'(smp_in.query_y) <<< 1) + kabs_pkg::POS_W'(prod_y);

   // Stage 2: magnitude and bounds check
   logic                        s2_valid_ff, s2_out_ff, s2_nx_ff, s2_ny_ff;
   logic [31:0]                 s2_mx_ff, s2_my_ff;
   logic [kabs_pkg::POS_W-1:0]  ax, ay;
   logic                        s2_out_in;

   assign ax = s1_px_ff[kabs_pkg::POS_W-1] ? kabs_pkg::POS_W'(-s1_px_ff)
                                           : kabs_pkg::POS_W'(s1_px_ff);
   assign ay = s1_py_ff[kabs_pkg::POS_W-1] ? kabs_pkg::POS_W'(-s1_py_ff)
                                           : kabs_pkg::POS_W'(s1_py_ff);
   assign s2_out_in = (ax >= kabs_pkg::POS_W'({cfg.x_half_width, 1'b0})) ||
                      (ay >= kabs_pkg::POS_W'({cfg.y_half_width, 1'b0}));

   // Stage 3: scale to pixel units
   logic                        s3_valid_ff, s3_out_ff, s3_nx_ff, s3_ny_ff;
   logic [kabs_pkg::OFF_W-1:0]  s3_ox_ff, s3_oy_ff;
   logic [63:0]                 mul_x, mul_y;

   assign mul_x = 64'(s2_mx_ff) * 64'(cfg.x_scale);
   assign mul_y = 64'(s2_my_ff) * 64'(cfg.y_scale);

   // Stage 4: pixel index, fraction and bank reads
   logic                        s4_valid_ff, s4_out_ff, s4_px0_ff, s4_py0_ff;
   logic [kabs_pkg::FR_W-1:0]   s4_fx_ff, s4_fy_ff;
   pix_type                     pxi, pyi;
   logic [kabs_pkg::BANK_AW-1:0] rd_addr [kabs_pkg::BANKS];
   logic [kabs_pkg::PIX_W-1:0]   rd_data [kabs_pkg::BANKS];

   assign pxi = to_pixel(s3_nx_ff, s3_ox_ff);
   assign pyi = to_pixel(s3_ny_ff, s3_oy_ff);

   // Each bank holds one of the four neighbours; pick the row and column it owns
   for (genvar b = 0; b < kabs_pkg::BANKS; b++) begin : g_bank
      localparam logic [1:0] BANK_SEL = 2'(b);
      logic [kabs_pkg::IX_W-1:0] row_b, col_b;
      assign row_b = pxi.ix + kabs_pkg::IX_W'(pxi.ix[0] != BANK_SEL[1]);
      assign col_b = pyi.ix + kabs_pkg::IX_W'(pyi.ix[0] != BANK_SEL[0]);
      assign rd_addr[b] = {row_b[kabs_pkg::IX_W-1:1], col_b[kabs_pkg::IX_W-1:1]};

      kabs_ram #(
         .WIDTH(kabs_pkg::PIX_W),
         .DEPTH(kabs_pkg::BANK_DEPTH)
      ) u_bank (
         .clock   (clock),
         .wr_en   (wr.we[b]),
         .wr_addr (wr.addr),
         .wr_data (wr.data),
         .rd_addr (rd_addr[b]),
         .rd_data (rd_data[b])
      );
   end

   // Stage 5: interpolate along x
   logic                        s5_valid_ff, s5_out_ff;
   logic [kabs_pkg::FR_W-1:0]   s5_fy_ff;
   logic [kabs_pkg::R_W-1:0]    s5_r1_ff, s5_r2_ff;
   logic [kabs_pkg::PIX_W-1:0]  p00, p10, p01, p11;
   logic [kabs_pkg::FR_W-1:0]   wfx, wfy;
   logic [kabs_pkg::R_W-1:0]    r1_in, r2_in;

   assign p00   = rd_data[{ s4_px0_ff,  s4_py0_ff}];
   assign p10   = rd_data[{~s4_px0_ff,  s4_py0_ff}];
   assign p01   = rd_data[{ s4_px0_ff, ~s4_py0_ff}];
   assign p11   = rd_data[{~s4_px0_ff, ~s4_py0_ff}];
   assign wfx   = kabs_pkg::FR_ONE - s4_fx_ff;
   assign r1_in = kabs_pkg::R_W'(wfx * p00) + kabs_pkg::R_W'(s4_fx_ff * p10);
   assign r2_in = kabs_pkg::R_W'(wfx * p01) + kabs_pkg::R_W'(s4_fx_ff * p11);

   // Stage 6: interpolate along y, or take the outside value
   logic                           s6_valid_ff;
   logic [kabs_pkg::SAMPLE_W-1:0]  s6_smp_ff, s6_smp_in;
   logic [49:0]                    yacc;

   assign wfy  = kabs_pkg::FR_ONE - s5_fy_ff;
   assign yacc = 50'(wfy * s5_r1_ff) + 50'(s5_fy_ff * s5_r2_ff);
   assign s6_smp_in = s5_out_ff ? kabs_pkg::SAMPLE_W'({cfg.outside_value, 32'd0})
                                : yacc[kabs_pkg::SAMPLE_W-1:0];

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= smp_in.valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      s1_px_ff  <= s1_px_in;
      s1_py_ff  <= s1_py_in;
      s2_out_ff <= s2_out_in;
      s2_nx_ff  <= s1_px_ff[kabs_pkg::POS_W-1];
      s2_ny_ff  <= s1_py_ff[kabs_pkg::POS_W-1];
      s2_mx_ff  <= ax[31:0];
      s2_my_ff  <= ay[31:0];
      s3_out_ff <= s2_out_ff;
      s3_nx_ff  <= s2_nx_ff;
      s3_ny_ff  <= s2_ny_ff;
      s3_ox_ff  <= mul_x[63:1];
      s3_oy_ff  <= mul_y[63:1];
      s4_out_ff <= s3_out_ff;
      s4_fx_ff  <= pxi.fr;
      s4_fy_ff  <= pyi.fr;
      s4_px0_ff <= pxi.ix[0];
      s4_py0_ff <= pyi.ix[0];
      s5_out_ff <= s4_out_ff;
      s5_fy_ff  <= s4_fy_ff;
      s5_r1_ff  <= r1_in;
      s5_r2_ff  <= r2_in;
      s6_smp_ff <= s6_smp_in;
   end

   assign out_valid  = s6_valid_ff;
   assign out_sample = s6_smp_ff;
   assign busy = s1_valid_ff | s2_valid_ff | s3_valid_ff | s4_valid_ff |
                 s5_valid_ff | s6_valid_ff;

endmodule

/* rtl/core/kernel_averaged_bilinear_sampler_core.sv */
// ----------------------------------------------------------------------------
// kernel_averaged_bilinear_sampler_core
// Box-averaged bilinear sampling of a 256 x 256 Q0.16 image store.
// ----------------------------------------------------------------------------
// Use:
//   req_* carries one request per handshake: operation 0 writes pixel_value at
//   (pixel_row, pixel_col), operation 1 asks the averaged intensity at
//   (query_x, query_y). Only a query returns a response on rsp_intensity.
//   csr_* writes one settings register per cycle at csr_index, no wait.
// Sequence:
//   A pixel write goes to the store on acceptance. A query issues K*K sample points, one per
//   cycle, into a six stage sample pipeline, drains it, then runs a one bit
//   per cycle divider over the 56 bit sum.
// Reset:
//   Settings return to their defaults, then the image store is zeroed by a
//   sweep over all 16384 addresses (four banks in parallel); req_ready stays low.
// Stall:
//   A finished response waits in the output register while rsp_ready is low;
//   the next request is taken meanwhile, and its response waits its turn.
// ----------------------------------------------------------------------------
`include "kernel_averaged_bilinear_sampler_core_macros.svh"

module kernel_averaged_bilinear_sampler_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_operation,
   input  logic [7:0]                    req_pixel_row,
   input  logic [7:0]                    req_pixel_col,
   input  logic [15:0]                   req_pixel_value,
   input  logic signed [31:0]            req_query_x,
   input  logic signed [31:0]            req_query_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_intensity,
   input  logic                          csr_wr_en,
   input  logic [kabs_pkg::CSR_AW-1:0]   csr_index,
   input  logic [kabs_pkg::CSR_DW-1:0]   csr_wdata
);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_ISSUE  = 6'b000100,
      ST_DRAIN  = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type                       state_ff, state_in;
   kabs_pkg::cfg_type               cfg_ff;
   logic [4:0]                      kside_ff;
   logic [kabs_pkg::BANK_AW-1:0]    clr_cnt_ff, clr_cnt_in;
   logic signed [31:0]              qx_ff, qy_ff;
   logic [kabs_pkg::KCNT_W-1:0]     i_ff, i_in, j_ff, j_in, km1_ff, half_ff;
   logic [kabs_pkg::KK_W-1:0]       kk_ff;
   logic [kabs_pkg::SUM_W-1:0]      sum_ff, sum_in;
   logic [kabs_pkg::KK_W-1:0]       rem_ff, rem_in;
   logic [kabs_pkg::DCNT_W-1:0]     div_cnt_ff, div_cnt_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [15:0]                     rsp_int_ff, rsp_int_in;

   logic                            req_take, load_ok;
   logic [kabs_pkg::K_W-1:0]        k_clamp;
   logic [kabs_pkg::KK_W:0]         rem_sh;
   logic [kabs_pkg::SUM_W:0]        rounded;
   kabs_pkg::smp_in_type            smp_in;
   kabs_pkg::wr_type                wr;
   logic                            smp_valid, pipe_busy;
   logic [kabs_pkg::SAMPLE_W-1:0]   smp_value;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;
   assign load_ok   = (32'(req_pixel_row) < kabs_pkg::IMAGE_SIDE) &&
                      (32'(req_pixel_col) < kabs_pkg::IMAGE_SIDE);

   // Clamp the kernel side into one to KERNEL_MAX
   always_comb begin
      if (kside_ff == 5'd0) begin
         k_clamp = kabs_pkg::K_W'(1);
      end else if (32'(kside_ff) > kabs_pkg::KERNEL_MAX) begin
         k_clamp = kabs_pkg::K_W'(kabs_pkg::KERNEL_MAX);
      end else begin
         k_clamp = kabs_pkg::K_W'(kside_ff);
      end
   end

   // Settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.x_scale       <= 32'd65536;
         cfg_ff.y_scale       <= 32'd65536;
         cfg_ff.x_half_width  <= '0;
         cfg_ff.y_half_width  <= '0;
         cfg_ff.kernel_pitch  <= '0;
         cfg_ff.outside_value <= 16'd66;
         kside_ff             <= 5'd1;
      end else if (csr_wr_en) begin
         case (csr_index)
            kabs_pkg::CSR_X_SCALE:      cfg_ff.x_scale       <= csr_wdata;
            kabs_pkg::CSR_Y_SCALE:      cfg_ff.y_scale       <= csr_wdata;
            kabs_pkg::CSR_X_HALF_WIDTH: cfg_ff.x_half_width  <= csr_wdata[30:0];
            kabs_pkg::CSR_Y_HALF_WIDTH: cfg_ff.y_half_width  <= csr_wdata[30:0];
            kabs_pkg::CSR_KERNEL_SIDE:  kside_ff             <= csr_wdata[4:0];
            kabs_pkg::CSR_KERNEL_PITCH: cfg_ff.kernel_pitch  <= csr_wdata[30:0];
            kabs_pkg::CSR_OUTSIDE:      cfg_ff.outside_value <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Image store writes: clearing sweep or a pixel load
   always_comb begin
      wr.we   = '0;
      wr.addr = {req_pixel_row[kabs_pkg::IX_W-1:1], req_pixel_col[kabs_pkg::IX_W-1:1]};
      wr.data = req_pixel_value;
      if (state_ff == ST_CLEAR) begin
         wr.we   = '1;
         wr.addr = clr_cnt_ff;
         wr.data = '0;
      end else if (req_take && !req_operation && load_ok) begin
         wr.we[{req_pixel_row[0], req_pixel_col[0]}] = 1'b1;
      end
   end

   // Sample point issue
   always_comb begin
      smp_in.valid   = (state_ff == ST_ISSUE);
      smp_in.query_x = qx_ff;
      smp_in.query_y = qy_ff;
      smp_in.coef_x  = $signed({1'b0, i_ff, 1'b1}) - $signed({1'b0, half_ff, 1'b0});
      smp_in.coef_y  = $signed({1'b0, j_ff, 1'b1}) - $signed({1'b0, half_ff, 1'b0});
   end

   kabs_sample_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .smp_in     (smp_in),
      .wr         (wr),
      .out_valid  (smp_valid),
      .out_sample (smp_value),
      .busy       (pipe_busy)
   );

   // Divider step and final rounding
   assign rem_sh  = {rem_ff, sum_ff[kabs_pkg::SUM_W-1]};
   assign rounded = (kabs_pkg::SUM_W+1)'(sum_ff) + (kabs_pkg::SUM_W+1)'(33'h080000000);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      sum_in       = sum_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_int_in   = rsp_int_ff;
      if (smp_valid) begin
         sum_in = sum_ff + kabs_pkg::SUM_W'(smp_value);
      end
      case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (&clr_cnt_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && req_operation) begin
               i_in     = '0;
               j_in     = '0;
               sum_in   = '0;
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            j_in = j_ff + 1'b1;
            if (j_ff == km1_ff) begin
               j_in = '0;
               i_in = i_ff + 1'b1;
               if (i_ff == km1_ff) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (!pipe_busy) begin
               rem_in     = '0;
               div_cnt_in = '0;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // One quotient bit a cycle, shifted into the sum register
            if (rem_sh >= (kabs_pkg::KK_W+1)'(kk_ff)) begin
               rem_in = kabs_pkg::KK_W'(rem_sh - (kabs_pkg::KK_W+1)'(kk_ff));
               sum_in = {sum_ff[kabs_pkg::SUM_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[kabs_pkg::KK_W-1:0];
               sum_in = {sum_ff[kabs_pkg::SUM_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 1'b1;
            if (32'(div_cnt_ff) == kabs_pkg::SUM_W - 1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_int_in   = (|rounded[kabs_pkg::SUM_W:48]) ? 16'hFFFF : rounded[47:32];
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers; latch the query on acceptance
   always_ff @(posedge clock) begin
      i_ff       <= i_in;
      j_ff       <= j_in;
      sum_ff     <= sum_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
      rsp_int_ff <= rsp_int_in;
      if (req_take && req_operation) begin
         qx_ff   <= req_query_x;
         qy_ff   <= req_query_y;
         km1_ff  <= kabs_pkg::KCNT_W'(k_clamp - 1'b1);
         half_ff <= kabs_pkg::KCNT_W'(k_clamp >> 1);
         kk_ff   <= kabs_pkg::KK_W'(k_clamp * k_clamp);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_intensity = rsp_int_ff;

   `KABS_ASSERT_IMP(a_sample_in_query, smp_valid, (state_ff == ST_ISSUE) || (state_ff == ST_DRAIN))
   `KABS_ASSERT_IMP(a_idle_pipe_empty, state_ff == ST_IDLE, !pipe_busy)
   `KABS_ASSERT_IMP(a_div_count_bound, state_ff == ST_DIVIDE, 32'(div_cnt_ff) < kabs_pkg::SUM_W)
   `KABS_ASSERT_NXT(a_done_loads_rsp, (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

/* tb/tb_kernel_averaged_bilinear_sampler_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kernel_averaged_bilinear_sampler_core
// Drives pixel loads and kernel queries through the request channel and checks
// every response against a bit-true box-averaged bilinear predictor, across
// directed edge cases, back-pressure and randomised settings.
// ----------------------------------------------------------------------------
module tb_kernel_averaged_bilinear_sampler_core;

   localparam bit OP_LOAD  = 1'b0;
   localparam bit OP_QUERY = 1'b1;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic                        req_operation;
   logic [7:0]                  req_pixel_row;
   logic [7:0]                  req_pixel_col;
   logic [15:0]                 req_pixel_value;
   logic signed [31:0]          req_query_x;
   logic signed [31:0]          req_query_y;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic [15:0]                 rsp_intensity;
   logic                        csr_wr_en;
   logic [kabs_pkg::CSR_AW-1:0] csr_index;
   logic [kabs_pkg::CSR_DW-1:0] csr_wdata;

   kernel_averaged_bilinear_sampler_core dut (.*);

   // Shadow settings and image
   longint unsigned sh_x_scale, sh_y_scale, sh_x_hw, sh_y_hw;
   longint unsigned sh_side, sh_pitch, sh_outside;
   logic [15:0]     shadow_image [0:65535];

   logic [15:0] intensity_q[$];
   int          mismatch_count;
   int          hold_off_cycles;
   int          burst_left;
   bit          no_gaps;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Map a half-unit position to pixel index and Q1.16 fraction
   function automatic void map_pixel(input longint p2, input longint unsigned scale,
                                     output int unsigned ix, output int unsigned fr);
      longint unsigned mag, off, c16, top, idx;
      mag = (p2 < 0) ? longint'(-p2) : p2;
      off = (mag * scale) >> 1;
      c16 = 64'd127 << 16;
      top = 64'd255 << 16;
      ix = 254;
      fr = 65536;
      if (p2 < 0) begin
         if (off > c16) begin
            ix = 0;
            fr = 0;
            return;
         end
         idx = c16 - off;
      end else begin
         if (off >= top) return;
         idx = c16 + off;
      end
      if (idx >= top) return;
      ix = 32'(idx >> 16);
      fr = 32'(idx & 64'hFFFF);
   endfunction

   function automatic longint unsigned pixel_at(int unsigned r, int unsigned c);
      return shadow_image[(r * 256 + c) % 65536];
   endfunction

   // One sample point as Q0.48
   function automatic longint unsigned sample_point(longint px2, longint py2);
      longint unsigned ax, ay, r1, r2;
      int unsigned x1, fx, y1, fy;
      ax = (px2 < 0) ? longint'(-px2) : px2;
      ay = (py2 < 0) ? longint'(-py2) : py2;
      if (ax >= 2 * sh_x_hw || ay >= 2 * sh_y_hw) return sh_outside << 32;
      map_pixel(px2, sh_x_scale, x1, fx);
      map_pixel(py2, sh_y_scale, y1, fy);
      r1 = longint'(65536 - fx) * pixel_at(x1, y1) + longint'(fx) * pixel_at(x1 + 1, y1);
      r2 = longint'(65536 - fx) * pixel_at(x1, y1 + 1)
         + longint'(fx) * pixel_at(x1 + 1, y1 + 1);
      return longint'(65536 - fy) * r1 + longint'(fy) * r2;
   endfunction

   function automatic logic [15:0] averaged_intensity(logic signed [31:0] qx,
                                                       logic signed [31:0] qy);
      longint unsigned k, sum, avg, res;
      longint half, px2, py2;
      k = sh_side;
      if (k < 1) k = 1;
      if (k > kabs_pkg::KERNEL_MAX) k = kabs_pkg::KERNEL_MAX;
      half = k / 2;
      sum = 0;
      for (int i = 0; i < k; i++) begin
         px2 = 2 * longint'(qx) + (2 * i + 1 - 2 * half) * longint'(sh_pitch);
         for (int j = 0; j < k; j++) begin
            py2 = 2 * longint'(qy) + (2 * j + 1 - 2 * half) * longint'(sh_pitch);
            sum += sample_point(px2, py2);
         end
      end
      avg = sum / (k * k);
      res = (avg + 64'h8000_0000) >> 32;
      if (res > 64'hFFFF) res = 64'hFFFF;
      return res[15:0];
   endfunction

   // Offer one request, wait for acceptance, then update the prediction
   task automatic send_request(bit op, logic [7:0] row, logic [7:0] col,
                               logic [15:0] value, logic signed [31:0] qx,
                               logic signed [31:0] qy);
      bit taken;
      req_valid       = 1'b1;
      req_operation   = op;
      req_pixel_row   = row;
      req_pixel_col   = col;
      req_pixel_value = value;
      req_query_x     = qx;
      req_query_y     = qy;
      do begin
         @(posedge clock);
         taken = req_ready;
         @(negedge clock);
      end while (!taken);
      if (op == OP_LOAD) shadow_image[row * 256 + col] = value;
      else intensity_q.insert(intensity_q.size(), averaged_intensity(qx, qy));
      req_valid = 1'b0;
      // Idle between bursts
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 30);
         if (!no_gaps) repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   task automatic load_pixel(logic [7:0] row, logic [7:0] col, logic [15:0] value);
      send_request(OP_LOAD, row, col, value, $urandom, $urandom);
   endtask

   task automatic query_at(logic signed [31:0] qx, logic signed [31:0] qy);
      send_request(OP_QUERY, 8'($urandom), 8'($urandom), 16'($urandom), qx, qy);
   endtask

   // Hold until all responses are in and any trailing load has landed
   task automatic drain;
      while (intensity_q.size() != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   task automatic write_csr(kabs_pkg::csr_index_type idx, logic [31:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         kabs_pkg::CSR_X_SCALE:      sh_x_scale = value;
         kabs_pkg::CSR_Y_SCALE:      sh_y_scale = value;
         kabs_pkg::CSR_X_HALF_WIDTH: sh_x_hw    = value[30:0];
         kabs_pkg::CSR_Y_HALF_WIDTH: sh_y_hw    = value[30:0];
         kabs_pkg::CSR_KERNEL_SIDE:  sh_side    = value[4:0];
         kabs_pkg::CSR_KERNEL_PITCH: sh_pitch   = value[30:0];
         kabs_pkg::CSR_OUTSIDE:      sh_outside = value[15:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(logic [31:0] xs, logic [31:0] ys, logic [31:0] xhw,
                                 logic [31:0] yhw, logic [31:0] side, logic [31:0] pitch,
                                 logic [31:0] outside);
      drain();
      write_csr(kabs_pkg::CSR_X_SCALE, xs);
      write_csr(kabs_pkg::CSR_Y_SCALE, ys);
      write_csr(kabs_pkg::CSR_X_HALF_WIDTH, xhw);
      write_csr(kabs_pkg::CSR_Y_HALF_WIDTH, yhw);
      write_csr(kabs_pkg::CSR_KERNEL_SIDE, side);
      write_csr(kabs_pkg::CSR_KERNEL_PITCH, pitch);
      write_csr(kabs_pkg::CSR_OUTSIDE, outside);
   endtask

   // Default settings: zero half width leaves every sample outside
   task automatic test_reset_defaults;
      query_at(0, 0);
      query_at(32'sh7FFF_FFFF, -32'sh8000_0000);
   endtask

   // Image corners, clamping beyond the edges and both scale extremes
   task automatic test_edges;
      apply_settings(32'd65536, 32'd65536, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 32'hFFFF);
      load_pixel(8'd0, 8'd0, 16'hFFFF);
      load_pixel(8'd255, 8'd255, 16'hFFFF);
      load_pixel(8'd127, 8'd127, 16'h0001);
      load_pixel(8'd128, 8'd128, 16'h8000);
      query_at(0, 0);
      query_at(-32'sh8000_0000, -32'sh8000_0000);
      query_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      query_at(-127, 128);
      query_at(-128, -128);
      apply_settings(32'hFFFF_FFFF, 32'd0, 32'd200, 32'd200, 0, 32'h7FFF_FFFF, 32'd0);
      query_at(1, -1);
      query_at(-1, 5);
      query_at(200, 0);
      query_at(199, -199);
   endtask

   // Kernel side above its range, and the full sixteen-by-sixteen box
   task automatic test_kernel_extremes;
      apply_settings(32'd32768, 32'd98304, 32'd100, 32'd150, 31, 32'd3, 32'h1234);
      query_at(10, -20);
      query_at(-95, 140);
      apply_settings(32'd65536, 32'd65536, 32'd64, 32'd64, 16, 32'd1, 32'hFFFF);
      query_at(0, 0);
      query_at(-60, 60);
   endtask

   // Stall the response side long enough to back up the input
   task automatic test_backpressure;
      apply_settings(32'd65536, 32'd65536, 32'd128, 32'd128, 2, 32'd1, 32'd500);
      hold_off_cycles = 3000;
      no_gaps = 1'b1;
      repeat (40) query_at($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
      no_gaps = 1'b0;
      drain();
      repeat (10) query_at($urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
   endtask

   // Random settings, each followed by a patch of loads and queries around it
   task automatic test_random;
      int unsigned hw, window;
      logic [31:0] side;
      for (int phase = 0; phase < 16; phase++) begin
         hw   = $urandom_range(1, 160);
         side = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 5);
         apply_settings($urandom_range(16384, 196608), $urandom_range(16384, 196608),
                        ($urandom_range(0, 7) == 0) ? $urandom : hw,
                        ($urandom_range(0, 7) == 0) ? $urandom : hw,
                        side, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6),
                        $urandom);
         no_gaps = ($urandom_range(0, 3) == 0);
         window  = $urandom_range(4, 60);
         repeat (80) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3:
                  load_pixel(8'(127 + $urandom_range(0, 2 * window) - window),
                             8'(127 + $urandom_range(0, 2 * window) - window),
                             16'($urandom));
               4: load_pixel(8'($urandom), 8'($urandom), 16'($urandom));
               5: query_at($urandom, $urandom);
               default:
                  query_at($urandom_range(0, 2 * hw + 20) - hw - 10,
                           $urandom_range(0, 2 * hw + 20) - hw - 10);
            endcase
         end
      end
      no_gaps = 1'b0;
   endtask

   // Response side: alternate free-flowing and choppy stretches
   initial begin
      int seg_left;
      bit choppy;
      seg_left = 0;
      choppy   = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready = 1'b0;
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(5, 200);
               choppy   = $urandom_range(0, 1);
            end
            seg_left--;
            rsp_ready = choppy ? ($urandom_range(0, 2) != 0) : 1'b1;
         end
      end
   end

   // Compare each response with the oldest prediction
   always @(posedge clock) begin
      logic [15:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (intensity_q.size() == 0) begin
            $error("unexpected response: intensity %0d", rsp_intensity);
            mismatch_count++;
         end else begin
            want = intensity_q.pop_front();
            if (rsp_intensity !== want) begin
               $error("intensity mismatch: expected %0d, actual %0d", want, rsp_intensity);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int waited;
      for (int a = 0; a < 65536; a++) shadow_image[a] = '0;
      sh_x_scale = 65536;
      sh_y_scale = 65536;
      sh_x_hw    = 0;
      sh_y_hw    = 0;
      sh_side    = 1;
      sh_pitch   = 0;
      sh_outside = 66;
      mismatch_count  = 0;
      hold_off_cycles = 0;
      burst_left      = 0;
      no_gaps         = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_LOAD;
      req_pixel_row   = '0;
      req_pixel_col   = '0;
      req_pixel_value = '0;
      req_query_x     = '0;
      req_query_y     = '0;
      csr_wr_en       = 1'b0;
      csr_index       = kabs_pkg::CSR_X_SCALE;
      csr_wdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // Hold until the store clearing sweep has finished
      while (!req_ready) @(negedge clock);

      test_reset_defaults();
      test_edges();
      test_kernel_extremes();
      test_backpressure();
      test_random();

      waited = 0;
      while (intensity_q.size() != 0 && waited < 200000) begin
         @(negedge clock);
         waited++;
      end
      repeat (400) @(negedge clock);
      if (mismatch_count == 0 && intensity_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/kabs_pkg.sv
rtl/core/kabs_ram.sv
rtl/core/kabs_sample_pipe.sv
rtl/core/kernel_averaged_bilinear_sampler_core.sv
tb/tb_kernel_averaged_bilinear_sampler_core.sv
